// File: src/kslm_pkg.sv
// Shared types and constants for the keypad scanner with LED matrix multiplexing.
`default_nettype none
package kslm_pkg;

   // Largest matrix side; the key timer store holds one entry per matrix position.
   localparam int unsigned DIM_W      = 3;
   localparam int unsigned MAX_DIM    = 8;
   localparam int unsigned TIMER_DEPTH = MAX_DIM * MAX_DIM;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // Idle drive pattern and the low bit used for one-hot selects.
   localparam logic [7:0] IDLE_ROW_DRIVE = 8'hFF;
   localparam logic [7:0] ONE_HOT_BASE   = 8'h01;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      CSR_ENABLE       = 3'd0,
      CSR_TOGGLE_STYLE = 3'd1,
      CSR_REACT_MOMENT = 3'd2,
      CSR_DEBOUNCE_MS  = 3'd3,
      CSR_ACTIVE_LEVEL = 3'd4
   } csr_index_type;

   // Input action codes; the remaining code changes no state and gives an idle result.
   typedef enum logic [1:0] {
      ACT_SCAN  = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_SET   = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_LOAD_SCAN,
      ST_LOAD_IDLE
   } state_type;

   typedef struct packed {
      logic [1:0]        action;
      logic [7:0]        sense_bits;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [7:0] led_column_select;
      logic [7:0] led_row_drive;
      logic [7:0] key_column_select;
      logic [7:0] key_column_state;
      logic       new_press;
   } rsp_type;

   typedef struct packed {
      logic        enable;
      logic        toggle_style;
      logic        react_moment;
      logic [15:0] debounce_ms;
      logic        active_level;
      logic        led_clear;
   } cfg_type;

   // Controller to datapath.
   typedef struct packed {
      logic start;
      logic step;
      logic fill_clear;
      logic fill_set;
      logic load_scan;
      logic load_idle;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic sweep_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// File: src/kslm_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module kslm_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: src/kslm_csr.sv
// Configuration registers behind the APB-style port.
`default_nettype none
module kslm_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [kslm_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [kslm_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic      [kslm_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                      pready,
   output kslm_pkg::cfg_type                         cfg
);

   logic        enable_ff, enable_in;
   logic        style_ff, style_in;
   logic        react_ff, react_in;
   logic [15:0] debounce_ff, debounce_in;
   logic        level_ff, level_in;
   logic        led_clear;
   logic        wr_stb;
   logic [2:0]  index;

   assign pready = 1'b1;
   assign index  = paddr[4:2];
   assign wr_stb = psel && penable && pwrite;

   // Register writes; a write of the style register also turns all LEDs off.
   always_comb begin
      enable_in   = enable_ff;
      style_in    = style_ff;
      react_in    = react_ff;
      debounce_in = debounce_ff;
      level_in    = level_ff;
      led_clear   = 1'b0;
      if (wr_stb) begin
         case (kslm_pkg::csr_index_type'(index))
            kslm_pkg::CSR_ENABLE: begin
               enable_in = pwdata[0];
            end
            kslm_pkg::CSR_TOGGLE_STYLE: begin
               style_in  = pwdata[0];
               led_clear = 1'b1;
            end
            kslm_pkg::CSR_REACT_MOMENT: begin
               react_in = pwdata[0];
            end
            kslm_pkg::CSR_DEBOUNCE_MS: begin
               debounce_in = pwdata[15:0];
            end
            kslm_pkg::CSR_ACTIVE_LEVEL: begin
               level_in = pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         style_ff    <= 1'b0;
         react_ff    <= 1'b0;
         debounce_ff <= 16'd50;
         level_ff    <= 1'b1;
      end else begin
         enable_ff   <= enable_in;
         style_ff    <= style_in;
         react_ff    <= react_in;
         debounce_ff <= debounce_in;
         level_ff    <= level_in;
      end
   end

   // Read mux.
   always_comb begin
      prdata = '0;
      case (kslm_pkg::csr_index_type'(index))
         kslm_pkg::CSR_ENABLE:       prdata[0]    = enable_ff;
         kslm_pkg::CSR_TOGGLE_STYLE: prdata[0]    = style_ff;
         kslm_pkg::CSR_REACT_MOMENT: prdata[0]    = react_ff;
         kslm_pkg::CSR_DEBOUNCE_MS:  prdata[15:0] = debounce_ff;
         kslm_pkg::CSR_ACTIVE_LEVEL: prdata[0]    = level_ff;
         default:                    prdata       = '0;
      endcase
   end

   assign cfg.enable       = enable_ff;
   assign cfg.toggle_style = style_ff;
   assign cfg.react_moment = react_ff;
   assign cfg.debounce_ms  = debounce_ff;
   assign cfg.active_level = level_ff;
   assign cfg.led_clear    = led_clear;

endmodule
`default_nettype wire

// File: src/kslm_ctrl.sv
// Controller state machine that sequences each transaction through the datapath.
`default_nettype none
module kslm_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic [1:0]             action,
   input  wire logic                   enable,
   input  wire kslm_pkg::status_type   status,
   output logic                        req_ready,
   output kslm_pkg::cmd_type           cmd
);

   kslm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kslm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         kslm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = kslm_pkg::ST_LOAD_IDLE;
               case (kslm_pkg::action_type'(action))
                  kslm_pkg::ACT_SCAN: begin
                     if (enable) begin
                        cmd.start = 1'b1;
                        state_in  = kslm_pkg::ST_SWEEP;
                     end
                  end
                  kslm_pkg::ACT_CLEAR: cmd.fill_clear = 1'b1;
                  kslm_pkg::ACT_SET:   cmd.fill_set   = 1'b1;
                  default: begin
                  end
               endcase
            end
         end
         kslm_pkg::ST_SWEEP: begin
            cmd.step = 1'b1;
            if (status.sweep_last) begin
               state_in = kslm_pkg::ST_LOAD_SCAN;
            end
         end
         kslm_pkg::ST_LOAD_SCAN: begin
            if (status.out_free) begin
               cmd.load_scan = 1'b1;
               state_in      = kslm_pkg::ST_IDLE;
            end
         end
         kslm_pkg::ST_LOAD_IDLE: begin
            if (status.out_free) begin
               cmd.load_idle = 1'b1;
               state_in      = kslm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kslm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: src/kslm_datapath.sv
// Datapath: LED and held-key flags, key timer sweep, and the result register.
`default_nettype none
module kslm_datapath #(
   parameter int unsigned ROW_COUNT    = 8,
   parameter int unsigned COLUMN_COUNT = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire kslm_pkg::req_type      req_data,
   input  wire kslm_pkg::cfg_type      cfg,
   input  wire kslm_pkg::cmd_type      cmd,
   input  wire logic                   rsp_ready,
   output kslm_pkg::status_type        status,
   output logic                        rsp_valid,
   output kslm_pkg::rsp_type           rsp_data
);

   localparam int unsigned DW = kslm_pkg::DIM_W;
   localparam logic [DW-1:0] LAST_ROW = DW'(ROW_COUNT - 1);
   localparam logic [DW-1:0] LAST_COL = DW'(COLUMN_COUNT - 1);
   localparam logic [7:0]    ROW_MASK = 8'((1 << ROW_COUNT) - 1);

   // LED and held flags, one byte of rows per column.
   logic [7:0] led_ff [kslm_pkg::MAX_DIM];
   logic [7:0] led_in [kslm_pkg::MAX_DIM];
   logic [7:0] held_ff [kslm_pkg::MAX_DIM];
   logic [7:0] held_in [kslm_pkg::MAX_DIM];

   logic [DW-1:0] col_ff, col_in;
   logic [DW-1:0] ptr_row_ff, ptr_row_in, ptr_col_ff, ptr_col_in;
   logic          ptr_v_ff, ptr_v_in;
   logic [DW-1:0] ev_row_ff, ev_row_in, ev_col_ff, ev_col_in;
   logic          ev_v_ff, ev_v_in;
   logic          press_ff, press_in;
   logic [7:0]    sense_ff, sense_in;
   logic [kslm_pkg::TIME_W-1:0] now_ff, now_in;
   logic [7:0]    drive_ff, drive_in;
   logic          rsp_valid_ff, rsp_valid_in;
   kslm_pkg::rsp_type rsp_ff, rsp_in;

   logic                         rd_en, wr_en;
   logic [kslm_pkg::TIME_W-1:0]  last_seen;
   logic [kslm_pkg::TIME_W-1:0]  age;
   logic                         hit, expired, was_held;

   // Key timer store, one entry per matrix position addressed as row and column.
   kslm_ram #(
      .WIDTH (kslm_pkg::TIME_W),
      .DEPTH (kslm_pkg::TIMER_DEPTH)
   ) u_timer_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ({ev_row_ff, ev_col_ff}),
      .wr_data (now_ff),
      .rd_en   (rd_en),
      .rd_addr ({ptr_row_ff, ptr_col_ff}),
      .rd_data (last_seen)
   );

   // Evaluation of the entry whose timer arrives this cycle.
   assign age      = now_ff - last_seen;
   assign expired  = age > {16'd0, cfg.debounce_ms};
   assign hit      = (ev_col_ff == col_ff) && (sense_ff[ev_row_ff] == cfg.active_level);
   assign was_held = held_ff[ev_col_ff][ev_row_ff];
   assign rd_en    = cmd.step && ptr_v_ff;
   assign wr_en    = cmd.step && ev_v_ff && hit;

   assign status.sweep_last = ev_v_ff && (ev_row_ff == LAST_ROW) && (ev_col_ff == LAST_COL);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      led_in       = led_ff;
      held_in      = held_ff;
      col_in       = col_ff;
      ptr_row_in   = ptr_row_ff;
      ptr_col_in   = ptr_col_ff;
      ptr_v_in     = ptr_v_ff;
      ev_row_in    = ev_row_ff;
      ev_col_in    = ev_col_ff;
      ev_v_in      = ev_v_ff;
      press_in     = press_ff;
      sense_in     = sense_ff;
      now_in       = now_ff;
      drive_in     = drive_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      // Whole-matrix LED fills.
      if (cmd.fill_set) begin
         for (int c = 0; c < kslm_pkg::MAX_DIM; c++) begin
            led_in[c] = 8'hFF;
         end
      end
      if (cmd.fill_clear || cfg.led_clear) begin
         for (int c = 0; c < kslm_pkg::MAX_DIM; c++) begin
            led_in[c] = 8'h00;
         end
      end

      // Capture the tick and the row drive from the LEDs as they stand now.
      if (cmd.start) begin
         sense_in   = req_data.sense_bits;
         now_in     = req_data.now_ms;
         drive_in   = ~(led_ff[col_ff] & ROW_MASK);
         press_in   = 1'b0;
         ptr_row_in = '0;
         ptr_col_in = '0;
         ptr_v_in   = 1'b1;
         ev_v_in    = 1'b0;
      end

      // One sweep step: issue the next read and evaluate the previous entry.
      if (cmd.step) begin
         ev_row_in = ptr_row_ff;
         ev_col_in = ptr_col_ff;
         ev_v_in   = ptr_v_ff;
         if (ptr_v_ff) begin
            if (ptr_col_ff == LAST_COL) begin
               ptr_col_in = '0;
               if (ptr_row_ff == LAST_ROW) begin
                  ptr_v_in = 1'b0;
               end else begin
                  ptr_row_in = ptr_row_ff + 1'b1;
               end
            end else begin
               ptr_col_in = ptr_col_ff + 1'b1;
            end
         end
         if (ev_v_ff) begin
            if (hit) begin
               if (!was_held) begin
                  held_in[ev_col_ff][ev_row_ff] = 1'b1;
                  press_in = 1'b1;
                  if (cfg.toggle_style) begin
                     led_in[ev_col_ff][ev_row_ff] = 1'b1;
                  end else if (!cfg.react_moment) begin
                     led_in[ev_col_ff][ev_row_ff] = !led_ff[ev_col_ff][ev_row_ff];
                  end
               end
            end else if (was_held && expired) begin
               held_in[ev_col_ff][ev_row_ff] = 1'b0;
               if (cfg.toggle_style) begin
                  led_in[ev_col_ff][ev_row_ff] = 1'b0;
               end else if (cfg.react_moment) begin
                  led_in[ev_col_ff][ev_row_ff] = !led_ff[ev_col_ff][ev_row_ff];
               end
            end
         end
      end

      // Result register: drains on ready, loads when the controller says so.
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_scan) begin
         rsp_valid_in              = 1'b1;
         rsp_in.led_column_select  = kslm_pkg::ONE_HOT_BASE << col_ff;
         rsp_in.led_row_drive      = drive_ff;
         rsp_in.key_column_select  = kslm_pkg::ONE_HOT_BASE << col_ff;
         rsp_in.key_column_state   = held_ff[col_ff] & ROW_MASK;
         rsp_in.new_press          = press_ff;
         col_in = (col_ff == LAST_COL) ? '0 : col_ff + 1'b1;
      end
      if (cmd.load_idle) begin
         rsp_valid_in              = 1'b1;
         rsp_in.led_column_select  = 8'h00;
         rsp_in.led_row_drive      = kslm_pkg::IDLE_ROW_DRIVE;
         rsp_in.key_column_select  = 8'h00;
         rsp_in.key_column_state   = 8'h00;
         rsp_in.new_press          = 1'b0;
      end
   end

   // Control and matrix state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < kslm_pkg::MAX_DIM; c++) begin
            led_ff[c]  <= 8'h00;
            held_ff[c] <= 8'h00;
         end
         col_ff       <= '0;
         ptr_v_ff     <= 1'b0;
         ev_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         led_ff       <= led_in;
         held_ff      <= held_in;
         col_ff       <= col_in;
         ptr_v_ff     <= ptr_v_in;
         ev_v_ff      <= ev_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ptr_row_ff <= ptr_row_in;
      ptr_col_ff <= ptr_col_in;
      ev_row_ff  <= ev_row_in;
      ev_col_ff  <= ev_col_in;
      press_ff   <= press_in;
      sense_ff   <= sense_in;
      now_ff     <= now_in;
      drive_ff   <= drive_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// File: src/keypad_scan_led_matrix.sv
// A scan tick's result is loaded after the sweep over the key timer memory, one entry per
// cycle; clear, set, disabled and unused actions load an idle result instead.
// Each transaction has its result loaded before the next one is taken in.
// While a result waits in the output register one more transaction is taken in, and its
// result waits until that one leaves.
// Synchronous reset turns all LEDs off, releases all keys and restores defaults.
`default_nettype none
module keypad_scan_led_matrix #(
   parameter int unsigned ROW_COUNT    = 8,
   parameter int unsigned COLUMN_COUNT = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire kslm_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output kslm_pkg::rsp_type                         rsp_data,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [kslm_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [kslm_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic      [kslm_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                      pready
);

   kslm_pkg::cfg_type    cfg;
   kslm_pkg::cmd_type    cmd;
   kslm_pkg::status_type status;

   // Configuration registers.
   kslm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Transaction sequencing.
   kslm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .action    (req_data.action),
      .enable    (cfg.enable),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // Matrix state, timer sweep and result register.
   kslm_datapath #(
      .ROW_COUNT    (ROW_COUNT),
      .COLUMN_COUNT (COLUMN_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg),
      .cmd       (cmd),
      .rsp_ready (rsp_ready),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
